// ===== hw/rtl/iq_snr_estimator_top_assert.svh =====
// Assertion macros shared by the estimator RTL.
`ifndef IQ_SNR_ESTIMATOR_TOP_ASSERT_SVH
`define IQ_SNR_ESTIMATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IQSNR_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IQSNR_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/iqsnr_pkg.sv =====
package iqsnr_pkg;

   localparam int unsigned SMP_W   = 16;
   localparam int unsigned CNT_W   = 16;
   localparam int unsigned ESUM_W  = 48;
   localparam int unsigned MSUM_W  = 40;
   localparam int unsigned DC_W    = 24;
   localparam int unsigned NOISE_W = 47;
   localparam int unsigned FSUM_W  = 56;
   localparam int unsigned MAG_W   = 25;
   localparam int unsigned ACC_W   = 51;
   localparam int unsigned WIDE_W  = 64;
   localparam int unsigned LOG_W   = 22;
   localparam int unsigned RAD_W   = 48;
   localparam int unsigned ROOT_W  = 24;

   localparam logic [CNT_W-1:0]   PAIRS_RESET    = 16'd1024;
   localparam logic [31:0]        DB_PER_LOG2    = 32'd197283;
   localparam logic [FSUM_W-1:0]  FSUM_MAX       = {FSUM_W{1'b1}};
   localparam logic [NOISE_W-1:0] NOISE_MAX      = {NOISE_W{1'b1}};

   localparam logic [0:0] CSR_CW_PAIRS  = 1'b0;
   localparam logic [0:0] CSR_FM0_PAIRS = 1'b1;

   localparam logic       OP_CW  = 1'b0;
   localparam logic       OP_FM0 = 1'b1;

   localparam logic [1:0] ST_VALID     = 2'd0;
   localparam logic [1:0] ST_NOISE_BAD = 2'd1;
   localparam logic [1:0] ST_SIG_BAD   = 2'd2;

   typedef struct packed {
      logic                    op;
      logic signed [SMP_W-1:0] sample_i;
      logic signed [SMP_W-1:0] sample_q;
   } req_type;

   typedef struct packed {
      logic signed [15:0]        snr_db;
      logic        [NOISE_W-1:0] noise_power;
      logic        [1:0]         status;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_SQ_I,
      S_SQ_Q,
      S_SUM,
      S_SQRT_GO,
      S_SQRT_WAIT,
      S_FM_ACC,
      S_COUNT,
      S_DIV_E,
      S_DIV_E_WAIT,
      S_DIV_DC,
      S_DIV_DC_WAIT,
      S_DC_SQ,
      S_NOISE,
      S_DIV_F,
      S_DIV_F_WAIT,
      S_JUDGE,
      S_LOG_NORM,
      S_LOG_SQ,
      S_LOG_STEP,
      S_LOG_DONE,
      S_DB_MUL,
      S_DB_RND,
      S_OUT
   } state_type;

endpackage

// ===== hw/rtl/iq_snr_estimator_top.sv =====
// Moment-based SNR estimator over a carrier segment followed by a modulated segment.
// Input beats carry op, sample_i and sample_q on req_data; the block raises req_stall
// while it works on a beat and lowers it when it is back in idle. Beats whose op does
// not match the current segment are dropped while the block stays in idle.
// A carrier beat inside the middle half of its segment takes two squarings on the
// shared multiplier and a 24-step square root; a modulated beat in its window two
// squarings and one accumulation; beats outside the window only a count update.
// The last carrier beat adds two 64-step divisions if its window is not empty. The last
// modulated beat adds one 64-step division if its window is not empty and, for a valid
// status only, two base-2 logarithms (a normalizing shift plus 16 squarings) and the
// dB scaling, then presents one result beat on rsp_data.
// The result sits in an output register; while rsp_stall is high it holds, and the
// block keeps taking beats until it has a next result ready, when it waits for the
// register to free up.
// csr_ready is always high; the user is to write segment lengths at csr_index 0 and 1
// only while idle, which the block does not enforce. Synchronous reset returns both
// lengths to 1024, clears all sums and counts and restarts with the carrier segment.
module iq_snr_estimator_top
   import iqsnr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [0:0]       csr_index,
   input  logic [CNT_W-1:0] csr_wdata
);

`include "iq_snr_estimator_top_assert.svh"

   state_type state_ff, state_in;

   logic [CNT_W-1:0]   cw_pairs_ff, cw_pairs_in;
   logic [CNT_W-1:0]   fm0_pairs_ff, fm0_pairs_in;
   logic               in_fm0_ff, in_fm0_in;
   logic [CNT_W-1:0]   cw_count_ff, cw_count_in;
   logic [CNT_W-1:0]   fm0_count_ff, fm0_count_in;
   logic [ESUM_W-1:0]  esum_ff, esum_in;
   logic [MSUM_W-1:0]  msum_ff, msum_in;
   logic [DC_W-1:0]    dc_ff, dc_in;
   logic [NOISE_W-1:0] noise_ff, noise_in;
   logic [FSUM_W-1:0]  fsum_ff, fsum_in;
   logic [MAG_W-1:0]   mag_i_ff, mag_i_in;
   logic [MAG_W-1:0]   mag_q_ff, mag_q_in;
   logic [WIDE_W-1:0]  prod_ff;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [WIDE_W-1:0]  avg_ff, avg_in;
   logic [WIDE_W-1:0]  logx_ff, logx_in;
   logic [5:0]         logp_ff, logp_in;
   logic [31:0]        logm_ff, logm_in;
   logic [3:0]         logk_ff, logk_in;
   logic [15:0]        logf_ff, logf_in;
   logic               second_ff, second_in;
   logic [LOG_W-1:0]   log_s_ff, log_s_in;
   logic [LOG_W-1:0]   dmag_ff, dmag_in;
   logic               dneg_ff, dneg_in;
   logic [15:0]        snr_ff, snr_in;
   logic [1:0]         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [31:0]        mul_a, mul_b;
   logic               sqrt_start, sqrt_done;
   logic [ROOT_W-1:0]  sqrt_root;
   logic               div_start, div_done;
   logic [WIDE_W-1:0]  div_dividend, div_quot;
   logic [CNT_W-1:0]   div_divisor;

   logic               accept, out_free, op_match, at_end;
   logic [CNT_W-1:0]   cur_pairs, cur_count, cnt_next;
   logic [CNT_W-1:0]   win_lo, win_hi, win_cnt, cw_win, fm_win;
   logic [CNT_W+1:0]   pairs_x3;
   logic [CNT_W+1:0]   cw_x3, fm_x3;
   logic signed [DC_W+1:0] diff_i, diff_q;
   logic [SMP_W-1:0]   abs_i, abs_q;
   logic [FSUM_W:0]    fsum_wide;
   logic [32:0]        sq_shift;
   logic [LOG_W-1:0]   log_val;
   logic [LOG_W:0]     log_diff;
   logic [WIDE_W-1:0]  rnd;
   logic [16:0]        r_mag;

   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign cur_pairs = in_fm0_ff ? fm0_pairs_ff : cw_pairs_ff;
   assign cur_count = in_fm0_ff ? fm0_count_ff : cw_count_ff;
   assign pairs_x3  = {2'b00, cur_pairs} + {1'b0, cur_pairs, 1'b0};
   assign win_lo    = {2'b00, cur_pairs[CNT_W-1:2]};
   assign win_hi    = pairs_x3[CNT_W+1:2];
   assign cw_x3     = {2'b00, cw_pairs_ff} + {1'b0, cw_pairs_ff, 1'b0};
   assign fm_x3     = {2'b00, fm0_pairs_ff} + {1'b0, fm0_pairs_ff, 1'b0};
   assign cw_win    = cw_x3[CNT_W+1:2] - {2'b00, cw_pairs_ff[CNT_W-1:2]};
   assign fm_win    = fm_x3[CNT_W+1:2] - {2'b00, fm0_pairs_ff[CNT_W-1:2]};
   assign win_cnt   = in_fm0_ff ? fm_win : cw_win;
   assign op_match  = in_fm0_ff ? (req_data.op == OP_FM0) : (req_data.op == OP_CW);
   assign cnt_next  = cur_count + 1'b1;
   assign at_end    = (cnt_next >= cur_pairs);

   assign diff_i = (DC_W+2)'(signed'({req_data.sample_i, 8'h00})) - $signed({2'b00, dc_ff});
   assign diff_q = (DC_W+2)'(signed'({req_data.sample_q, 8'h00})) - $signed({2'b00, dc_ff});

   assign abs_i = req_data.sample_i[SMP_W-1] ? SMP_W'(-req_data.sample_i) : req_data.sample_i;
   assign abs_q = req_data.sample_q[SMP_W-1] ? SMP_W'(-req_data.sample_q) : req_data.sample_q;

   iqsnr_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand ({acc_ff[31:0], 16'h0000}),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   iqsnr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && op_match) begin
               if (cur_count >= win_lo && cur_count < win_hi) begin
                  state_in = S_SQ_I;
               end else begin
                  state_in = S_COUNT;
               end
            end
         end
         S_SQ_I:      state_in = S_SQ_Q;
         S_SQ_Q:      state_in = S_SUM;
         S_SUM:       state_in = in_fm0_ff ? S_FM_ACC : S_SQRT_GO;
         S_SQRT_GO:   state_in = S_SQRT_WAIT;
         S_SQRT_WAIT: state_in = sqrt_done ? S_COUNT : S_SQRT_WAIT;
         S_FM_ACC:    state_in = S_COUNT;
         S_COUNT: begin
            if (!at_end) begin
               state_in = S_IDLE;
            end else if (win_cnt == '0) begin
               state_in = in_fm0_ff ? S_JUDGE : S_DC_SQ;
            end else begin
               state_in = in_fm0_ff ? S_DIV_F : S_DIV_E;
            end
         end
         S_DIV_E:       state_in = S_DIV_E_WAIT;
         S_DIV_E_WAIT:  state_in = div_done ? S_DIV_DC : S_DIV_E_WAIT;
         S_DIV_DC:      state_in = S_DIV_DC_WAIT;
         S_DIV_DC_WAIT: state_in = div_done ? S_DC_SQ : S_DIV_DC_WAIT;
         S_DC_SQ:       state_in = S_NOISE;
         S_NOISE:       state_in = S_IDLE;
         S_DIV_F:       state_in = S_DIV_F_WAIT;
         S_DIV_F_WAIT:  state_in = div_done ? S_JUDGE : S_DIV_F_WAIT;
         S_JUDGE: begin
            if (noise_ff == '0 || avg_ff <= {17'd0, noise_ff}) begin
               state_in = S_OUT;
            end else begin
               state_in = S_LOG_NORM;
            end
         end
         S_LOG_NORM: state_in = logx_ff[WIDE_W-1] ? S_LOG_SQ : S_LOG_NORM;
         S_LOG_SQ:   state_in = S_LOG_STEP;
         S_LOG_STEP: state_in = (logk_ff == 4'd0) ? S_LOG_DONE : S_LOG_SQ;
         S_LOG_DONE: state_in = second_ff ? S_DB_MUL : S_LOG_NORM;
         S_DB_MUL:   state_in = S_DB_RND;
         S_DB_RND:   state_in = S_OUT;
         S_OUT:      state_in = out_free ? S_IDLE : S_OUT;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cw_pairs_in  = cw_pairs_ff;
      fm0_pairs_in = fm0_pairs_ff;
      in_fm0_in    = in_fm0_ff;
      cw_count_in  = cw_count_ff;
      fm0_count_in = fm0_count_ff;
      esum_in      = esum_ff;
      msum_in      = msum_ff;
      dc_in        = dc_ff;
      noise_in     = noise_ff;
      fsum_in      = fsum_ff;
      mag_i_in     = mag_i_ff;
      mag_q_in     = mag_q_ff;
      acc_in       = acc_ff;
      avg_in       = avg_ff;
      logx_in      = logx_ff;
      logp_in      = logp_ff;
      logm_in      = logm_ff;
      logk_in      = logk_ff;
      logf_in      = logf_ff;
      second_in    = second_ff;
      log_s_in     = log_s_ff;
      dmag_in      = dmag_ff;
      dneg_in      = dneg_ff;
      snr_in       = snr_ff;
      status_in    = status_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mul_a        = '0;
      mul_b        = '0;
      sqrt_start   = 1'b0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = win_cnt;
      fsum_wide    = {1'b0, fsum_ff} + (FSUM_W+1)'(acc_ff[ACC_W-1:8]);
      sq_shift     = prod_ff[WIDE_W-1:31];
      log_val      = {logp_ff, logf_ff};
      log_diff     = {1'b0, log_s_ff} - {1'b0, log_val};
      rnd          = prod_ff + 64'h0000_0000_0080_0000;
      r_mag        = rnd[40:24];

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CW_PAIRS:  cw_pairs_in  = csr_wdata;
            CSR_FM0_PAIRS: fm0_pairs_in = csr_wdata;
            default:       cw_pairs_in  = cw_pairs_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (in_fm0_ff) begin
               mag_i_in = diff_i[DC_W+1] ? MAG_W'(-diff_i) : MAG_W'(diff_i);
               mag_q_in = diff_q[DC_W+1] ? MAG_W'(-diff_q) : MAG_W'(diff_q);
            end else begin
               mag_i_in = MAG_W'(abs_i);
               mag_q_in = MAG_W'(abs_q);
            end
         end
         S_SQ_I: begin
            mul_a = 32'(mag_i_ff);
            mul_b = 32'(mag_i_ff);
         end
         S_SQ_Q: begin
            mul_a  = 32'(mag_q_ff);
            mul_b  = 32'(mag_q_ff);
            acc_in = prod_ff[ACC_W-1:0];
         end
         S_SUM: acc_in = ACC_W'(acc_ff + prod_ff[ACC_W-1:0]);
         S_SQRT_GO: sqrt_start = 1'b1;
         S_SQRT_WAIT: begin
            if (sqrt_done) begin
               esum_in = ESUM_W'(esum_ff + ESUM_W'(acc_ff[31:0]));
               msum_in = MSUM_W'(msum_ff + MSUM_W'(sqrt_root));
            end
         end
         S_FM_ACC: begin
            if (fsum_wide >= {1'b0, FSUM_MAX}) begin
               fsum_in = FSUM_MAX;
            end else begin
               fsum_in = fsum_wide[FSUM_W-1:0];
            end
         end
         S_COUNT: begin
            if (in_fm0_ff) begin
               fm0_count_in = cnt_next;
            end else begin
               cw_count_in = cnt_next;
            end
            if (at_end && win_cnt == '0) begin
               avg_in = '0;
               dc_in  = '0;
            end
         end
         S_DIV_E: begin
            div_start    = 1'b1;
            div_dividend = {esum_ff, 16'h0000};
         end
         S_DIV_E_WAIT: begin
            if (div_done) begin
               avg_in = div_quot;
            end
         end
         S_DIV_DC: begin
            div_start    = 1'b1;
            div_dividend = WIDE_W'(msum_ff);
         end
         S_DIV_DC_WAIT: begin
            if (div_done) begin
               dc_in = div_quot[DC_W-1:0];
            end
         end
         S_DC_SQ: begin
            mul_a = 32'(dc_ff);
            mul_b = 32'(dc_ff);
         end
         S_NOISE: begin
            if (avg_ff > prod_ff) begin
               if ((avg_ff - prod_ff) > WIDE_W'(NOISE_MAX)) begin
                  noise_in = NOISE_MAX;
               end else begin
                  noise_in = NOISE_W'(avg_ff - prod_ff);
               end
            end else begin
               noise_in = '0;
            end
            in_fm0_in    = 1'b1;
            fm0_count_in = '0;
            fsum_in      = '0;
         end
         S_DIV_F: begin
            div_start    = 1'b1;
            div_dividend = {fsum_ff, 8'h00};
         end
         S_DIV_F_WAIT: begin
            if (div_done) begin
               avg_in = div_quot;
            end
         end
         S_JUDGE: begin
            snr_in    = '0;
            second_in = 1'b0;
            logp_in   = 6'd63;
            logx_in   = avg_ff - {17'd0, noise_ff};
            if (noise_ff == '0) begin
               status_in = ST_NOISE_BAD;
            end else if (avg_ff <= {17'd0, noise_ff}) begin
               status_in = ST_SIG_BAD;
            end else begin
               status_in = ST_VALID;
            end
         end
         S_LOG_NORM: begin
            if (logx_ff[WIDE_W-1]) begin
               logm_in = logx_ff[WIDE_W-1:32];
               logk_in = 4'd15;
               logf_in = '0;
            end else begin
               logx_in = {logx_ff[WIDE_W-2:0], 1'b0};
               logp_in = logp_ff - 1'b1;
            end
         end
         S_LOG_SQ: begin
            mul_a = logm_ff;
            mul_b = logm_ff;
         end
         S_LOG_STEP: begin
            if (sq_shift[32]) begin
               logf_in[logk_ff] = 1'b1;
               logm_in          = sq_shift[32:1];
            end else begin
               logm_in = sq_shift[31:0];
            end
            logk_in = logk_ff - 1'b1;
         end
         S_LOG_DONE: begin
            if (!second_ff) begin
               log_s_in  = log_val;
               logx_in   = {17'd0, noise_ff};
               logp_in   = 6'd63;
               second_in = 1'b1;
            end else begin
               dneg_in = log_diff[LOG_W];
               dmag_in = log_diff[LOG_W] ? LOG_W'(-log_diff) : log_diff[LOG_W-1:0];
            end
         end
         S_DB_MUL: begin
            mul_a = 32'(dmag_ff);
            mul_b = DB_PER_LOG2;
         end
         S_DB_RND: begin
            if (dneg_ff) begin
               snr_in = (r_mag > 17'd32768) ? 16'h8000 : 16'(-r_mag);
            end else begin
               snr_in = (r_mag > 17'd32767) ? 16'h7fff : r_mag[15:0];
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.snr_db      = snr_ff;
               rsp_data_in.noise_power = noise_ff;
               rsp_data_in.status      = status_ff;
               cw_count_in             = '0;
               fm0_count_in            = '0;
               esum_in                 = '0;
               msum_in                 = '0;
               fsum_in                 = '0;
               in_fm0_in               = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cw_pairs_ff  <= PAIRS_RESET;
         fm0_pairs_ff <= PAIRS_RESET;
         in_fm0_ff    <= 1'b0;
         cw_count_ff  <= '0;
         fm0_count_ff <= '0;
         esum_ff      <= '0;
         msum_ff      <= '0;
         dc_ff        <= '0;
         noise_ff     <= '0;
         fsum_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cw_pairs_ff  <= cw_pairs_in;
         fm0_pairs_ff <= fm0_pairs_in;
         in_fm0_ff    <= in_fm0_in;
         cw_count_ff  <= cw_count_in;
         fm0_count_ff <= fm0_count_in;
         esum_ff      <= esum_in;
         msum_ff      <= msum_in;
         dc_ff        <= dc_in;
         noise_ff     <= noise_in;
         fsum_ff      <= fsum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_i_ff    <= mag_i_in;
      mag_q_ff    <= mag_q_in;
      prod_ff     <= mul_a * mul_b;
      acc_ff      <= acc_in;
      avg_ff      <= avg_in;
      logx_ff     <= logx_in;
      logp_ff     <= logp_in;
      logm_ff     <= logm_in;
      logk_ff     <= logk_in;
      logf_ff     <= logf_in;
      second_ff   <= second_in;
      log_s_ff    <= log_s_in;
      dmag_ff     <= dmag_in;
      dneg_ff     <= dneg_in;
      snr_ff      <= snr_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   `IQSNR_ASSERT_NEXT(a_out_loads, (state_ff == S_OUT) && out_free, rsp_valid_ff,
                      "result not presented after output stage")
   `IQSNR_ASSERT_NOW(a_rsp_source, $rose(rsp_valid_ff), $past(state_ff == S_OUT),
                     "result beat raised outside output stage")
   `IQSNR_ASSERT_NOW(a_busy_stall, state_ff != S_IDLE, req_stall,
                     "input beat taken while busy")

endmodule

// ===== hw/rtl/iqsnr_sqrt.sv =====
module iqsnr_sqrt
   import iqsnr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAD_W-1:0]  radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   localparam int unsigned STEPS = RAD_W / 2;
   localparam int unsigned REM_W = ROOT_W + 2;

   logic [RAD_W-1:0]        rad_ff, rad_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [ROOT_W-1:0]       root_ff, root_in;
   logic [$clog2(STEPS)-1:0] cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [REM_W+1:0]        rem_sh;
   logic [REM_W+1:0]        trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = REM_W'(rem_sh - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(rem_sh);
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ($clog2(STEPS))'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== hw/rtl/iqsnr_div.sv =====
module iqsnr_div
   import iqsnr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WIDE_W-1:0] dividend,
   input  logic [CNT_W-1:0]  divisor,
   output logic              done,
   output logic [WIDE_W-1:0] quotient
);

   logic [WIDE_W-1:0]         dvd_ff, dvd_in;
   logic [CNT_W-1:0]          dsr_ff, dsr_in;
   logic [CNT_W-1:0]          rem_ff, rem_in;
   logic [$clog2(WIDE_W)-1:0] cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [CNT_W:0]            rem_sh;

   always_comb begin
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff, dvd_ff[WIDE_W-1]};
      if (start) begin
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_in = CNT_W'(rem_sh - {1'b0, dsr_ff});
            dvd_in = {dvd_ff[WIDE_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[CNT_W-1:0];
            dvd_in = {dvd_ff[WIDE_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ($clog2(WIDE_W))'(WIDE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
   import iqsnr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 4000000;
   localparam int unsigned SETTLE_CYCLES = 400;
   localparam int unsigned LONG_HOLD = 3000;
   localparam longint unsigned MASK48 = (64'd1 << 48) - 1;
   localparam longint unsigned MASK40 = (64'd1 << 40) - 1;
   localparam longint unsigned MASK24 = (64'd1 << 24) - 1;
   localparam longint unsigned LIM47 = (64'd1 << 47) - 1;
   localparam longint unsigned LIM56 = (64'd1 << 56) - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [0:0] csr_index = CSR_CW_PAIRS;
   logic [CNT_W-1:0] csr_wdata = '0;

   req_type beat_queue[$];
   rsp_type snr_expected[$];
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_taken = 0;
   int unsigned hold_left = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   // Estimator state mirrored by the testbench.
   logic [15:0] cw_len, fm0_len, cw_seen, fm0_seen;
   longint unsigned e_acc, m_acc, dc_est, noise_est, f_acc;
   logic fm0_phase;

   iq_snr_estimator_top DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint unsigned mag_sq(longint a);
      longint unsigned m;
      m = (a < 0) ? longint'(-a) : longint'(a);
      return m * m;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic longint unsigned log2_fix(longint unsigned x);
      int unsigned p;
      longint unsigned m, frac;
      p = 63;
      frac = 0;
      while (x[p] == 1'b0) p--;
      m = (p >= 31) ? (x >> (p - 31)) : (x << (31 - p));
      for (int k = 15; k >= 0; k--) begin
         m = (m * m) >> 31;
         if (m >= (64'd1 << 32)) begin
            frac = frac | (64'd1 << k);
            m = m >> 1;
         end
      end
      return (longint'(p) << 16) | frac;
   endfunction

   function automatic longint unsigned window_size(logic [15:0] len);
      return (3 * longint'(len)) / 4 - longint'(len) / 4;
   endfunction

   function automatic bit in_window(logic [15:0] idx, logic [15:0] len);
      return longint'(idx) >= longint'(len) / 4 && longint'(idx) < (3 * longint'(len)) / 4;
   endfunction

   task automatic reset_estimate();
      cw_len = PAIRS_RESET;
      fm0_len = PAIRS_RESET;
      cw_seen = 0;
      fm0_seen = 0;
      e_acc = 0;
      m_acc = 0;
      dc_est = 0;
      noise_est = 0;
      f_acc = 0;
      fm0_phase = 1'b0;
   endtask

   task automatic close_carrier();
      longint unsigned cnt, e_avg, dc2, n;
      cnt = window_size(cw_len);
      e_avg = 0;
      if (cnt != 0) begin
         e_avg = (e_acc << 16) / cnt;
         dc_est = (m_acc / cnt) & MASK24;
      end else begin
         dc_est = 0;
      end
      dc2 = dc_est * dc_est;
      if (e_avg > dc2) begin
         n = e_avg - dc2;
         noise_est = (n > LIM47) ? LIM47 : n;
      end else begin
         noise_est = 0;
      end
   endtask

   task automatic predict_beat(req_type b);
      longint si, sq, dc, d;
      longint unsigned e, t, cnt, f_avg, mag, r;
      rsp_type res;
      si = b.sample_i;
      sq = b.sample_q;
      if (!fm0_phase) begin
         if (b.op != OP_CW) return;
         if (in_window(cw_seen, cw_len)) begin
            e = mag_sq(si) + mag_sq(sq);
            e_acc = (e_acc + e) & MASK48;
            m_acc = (m_acc + int_sqrt(e << 16)) & MASK40;
         end
         cw_seen++;
         if (cw_seen >= cw_len) begin
            close_carrier();
            fm0_phase = 1'b1;
            fm0_seen = 0;
            f_acc = 0;
         end
         return;
      end
      if (b.op != OP_FM0) return;
      if (in_window(fm0_seen, fm0_len)) begin
         dc = longint'(dc_est);
         t = (mag_sq(si * 256 - dc) + mag_sq(sq * 256 - dc)) >> 8;
         if (t >= LIM56 - f_acc) f_acc = LIM56;
         else f_acc = f_acc + t;
      end
      fm0_seen++;
      if (fm0_seen < fm0_len) return;
      cnt = window_size(fm0_len);
      f_avg = 0;
      if (cnt != 0) f_avg = ((f_acc / cnt) << 8) + ((f_acc % cnt) << 8) / cnt;
      res = '0;
      res.noise_power = noise_est[NOISE_W-1:0];
      if (noise_est == 0) begin
         res.status = ST_NOISE_BAD;
      end else if (f_avg <= noise_est) begin
         res.status = ST_SIG_BAD;
      end else begin
         d = longint'(log2_fix(f_avg - noise_est)) - longint'(log2_fix(noise_est));
         mag = (d < 0) ? longint'(-d) : longint'(d);
         r = (mag * DB_PER_LOG2 + (64'd1 << 23)) >> 24;
         res.status = ST_VALID;
         if (d < 0) begin
            if (r > 32768) r = 32768;
            res.snr_db = 16'(-r);
         end else begin
            if (r > 32767) r = 32767;
            res.snr_db = 16'(r);
         end
      end
      snr_expected.push_back(res);
      cw_seen = 0;
      fm0_seen = 0;
      e_acc = 0;
      m_acc = 0;
      f_acc = 0;
      fm0_phase = 1'b0;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         reset_estimate();
      end else begin
         if (req_valid && !req_stall) predict_beat(req_data);
         if (!req_valid || !req_stall) begin
            if (beat_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= beat_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (snr_expected.size() == 0) begin
               $error("result beat with nothing expected");
               error_count++;
            end else begin
               rsp_type want;
               want = snr_expected.pop_front();
               if (rsp_data.snr_db !== want.snr_db) begin
                  $error("snr_db expected %0d actual %0d", want.snr_db, rsp_data.snr_db);
                  error_count++;
               end
               if (rsp_data.noise_power !== want.noise_power) begin
                  $error("noise_power expected %0d actual %0d", want.noise_power,
                         rsp_data.noise_power);
                  error_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_data.status);
                  error_count++;
               end
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_taken != hold_requests) begin
            hold_taken = hold_requests;
            hold_left = LONG_HOLD;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   task automatic wait_drained();
      do @(posedge clock);
      while (beat_queue.size() != 0 || req_valid || snr_expected.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock);
      while (!csr_ready);
      if (idx == CSR_CW_PAIRS) cw_len = value;
      else fm0_len = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic push_beat(logic op, int si, int sq);
      req_type b;
      b.op = op;
      b.sample_i = 16'(si);
      b.sample_q = 16'(sq);
      beat_queue.push_back(b);
   endtask

   function automatic int jitter(int center, int spread);
      int v;
      v = center + $signed($urandom_range(2 * spread)) - spread;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   // Random carrier and modulated segment with occasional wrong-segment beats.
   task automatic push_segment(int unsigned cw_n, int unsigned fm0_n, inout int unsigned used);
      int unsigned style, amp, spread;
      style = $urandom_range(3);
      amp = $urandom_range(50, 20000);
      spread = $urandom_range(0, 400);
      for (int unsigned k = 0; k < cw_n; k++) begin
         if ($urandom_range(9) == 0) push_beat(OP_FM0, $urandom, $urandom);
         if (style == 0) push_beat(OP_CW, $urandom, $urandom);
         else push_beat(OP_CW, jitter(amp, spread), jitter(0, spread));
         used++;
      end
      for (int unsigned k = 0; k < fm0_n; k++) begin
         if ($urandom_range(9) == 0) push_beat(OP_CW, $urandom, $urandom);
         case (style)
            0, 1: push_beat(OP_FM0, $urandom, $urandom);
            2: push_beat(OP_FM0, jitter(amp, spread), jitter(0, spread));
            default: push_beat(OP_FM0, jitter(((k & 1) != 0) ? amp : -amp, spread),
                               jitter(0, spread));
         endcase
         used++;
      end
   endtask

   function automatic logic [15:0] pick_len();
      return ($urandom_range(99) < 5) ? 16'($urandom_range(40, 96)) : 16'($urandom_range(4, 20));
   endfunction

   task automatic random_phase(int unsigned target);
      int unsigned used;
      used = 0;
      while (used < target) begin
         if ($urandom_range(2) == 0) begin
            wait_drained();
            write_csr(CSR_CW_PAIRS, pick_len());
            write_csr(CSR_FM0_PAIRS, pick_len());
         end
         push_segment(cw_len, fm0_len, used);
         while (beat_queue.size() > 40) @(posedge clock);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_csr(CSR_CW_PAIRS, 16'd4);
      write_csr(CSR_FM0_PAIRS, 16'd4);
      push_beat(OP_CW, 32767, -32768);
      push_beat(OP_FM0, 1, 1);
      push_beat(OP_CW, -32768, -32768);
      push_beat(OP_CW, 32767, 32767);
      push_beat(OP_CW, 0, 0);
      push_beat(OP_CW, 5, 5);
      push_beat(OP_FM0, -32768, 32767);
      push_beat(OP_FM0, 32767, -32768);
      push_beat(OP_FM0, -1, 0);
      push_beat(OP_FM0, 0, -1);
      push_beat(OP_CW, 0, 0);
      push_beat(OP_CW, 1000, 0);
      push_beat(OP_CW, 0, 0);
      push_beat(OP_CW, 0, 0);
      for (int k = 0; k < 4; k++) push_beat(OP_FM0, 500, 500);
      wait_drained();

      // Maximum lengths, then a shorter carrier length while that segment is underway.
      write_csr(CSR_CW_PAIRS, 16'hFFFF);
      write_csr(CSR_FM0_PAIRS, 16'hFFFF);
      for (int k = 0; k < 6; k++) push_beat(OP_CW, 300 * k, -300 * k);
      wait_drained();
      write_csr(CSR_CW_PAIRS, 16'd5);
      write_csr(CSR_FM0_PAIRS, 16'd4);
      push_beat(OP_CW, 123, 456);
      for (int k = 0; k < 4; k++) push_beat(OP_FM0, 9000 * k, 100);
      wait_drained();

      send_idle_pct = 14;
      recv_idle_pct = 81;
      random_phase(400);
      send_idle_pct = 81;
      recv_idle_pct = 14;
      random_phase(400);
      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests++;
      random_phase(400);

      wait_drained();
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== iq_snr_estimator_top.f =====
+incdir+hw/rtl
hw/rtl/iqsnr_pkg.sv
hw/rtl/iqsnr_sqrt.sv
hw/rtl/iqsnr_div.sv
hw/rtl/iq_snr_estimator_top.sv
tb/tb_top.sv
